/* hdl/lsd_pkg.sv */
// Shared constants and types for the LRU slot directory.
package lsd_pkg;

  localparam int ENTRIES_DEF = 8;
  localparam int KEY_W       = 32;
  localparam int SLOT_OUT_W  = 3;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_FORCE  = 1'b1;

  typedef logic [KEY_W-1:0] key_t;

  // per-cell status seen by the front-entry select
  typedef struct packed {
    logic sel;    // this cell is the target position
    logic match;  // used entry whose key equals the lookup key
    logic used;
  } cell_stat_t;

endpackage

/* hdl/lru_slot_directory.sv */
// Top level of the fully associative LRU slot directory.
//
// Input stream: s_axis_tdata carries a 32-bit key, s_axis_tuser the operation
// (lookup with load on miss, or force load). Output stream: one result per
// input with hit flag, physical slot, evicted flag and evicted key.
// A transfer is taken when tvalid and tready are both high.
//
// The accept cycle registers the request; the update cycle, once the output
// register is free, runs the compare across the row of cells, picks the target
// position (first match, else first unused, else the least recent) and
// shifts the cells up to the target back by one while the front cell takes
// the entry. The result is registered at that same edge. The single request
// register holds one request, so the next is taken only after this update.
// A new request is accepted while the previous result still waits; if the
// receiver stalls, the pending request holds until the output register frees.
// Reset (rst, synchronous) empties the directory: position i holds slot i,
// all keys zero, nothing used. No clearing pass is needed.
module lru_slot_directory #(
  parameter int ENTRIES = lsd_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] key
  input  logic [0:0]  s_axis_tuser,  // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // [0] hit, [3:1] slot, [4] evicted_valid,
                                     // [36:5] evicted_key, [39:37] zero
);
  import lsd_pkg::*;

  localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic        busy;
  logic        req_force;
  key_t        req_key;
  logic        update;

  logic [SLOT_W-1:0] cell_slot [ENTRIES];
  key_t              cell_key  [ENTRIES];
  logic              cell_used [ENTRIES];
  cell_stat_t        stat      [ENTRIES];
  logic [ENTRIES:0]  taken;

  logic [SLOT_W-1:0] front_slot;
  key_t              front_key;
  logic              front_match;
  logic              front_used;

  logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;

  assign s_axis_tready = !busy;
  assign update        = busy && (!m_axis_tvalid || m_axis_tready);
  assign taken[0]      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      busy <= 1'b1;
    end else if (update) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_key   <= s_axis_tdata;
      req_force <= s_axis_tuser[0];
    end
  end

  generate
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      logic [SLOT_W-1:0] p_slot;
      key_t              p_key;
      logic              p_used;
      if (i == 0) begin : g_front
        assign p_slot = front_slot;
        assign p_key  = req_key;
        assign p_used = 1'b1;
      end else begin : g_chain
        assign p_slot = cell_slot[i-1];
        assign p_key  = cell_key[i-1];
        assign p_used = cell_used[i-1];
      end
      lsd_cell #(
        .SLOT_W    (SLOT_W),
        .RESET_SLOT(i),
        .IS_LAST   (i == ENTRIES - 1)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .update    (update),
        .force_load(req_force),
        .lookup_key(req_key),
        .prev_slot (p_slot),
        .prev_key  (p_key),
        .prev_used (p_used),
        .taken_in  (taken[i]),
        .taken_out (taken[i+1]),
        .slot      (cell_slot[i]),
        .key       (cell_key[i]),
        .used      (cell_used[i]),
        .stat      (stat[i])
      );
    end
  endgenerate

  // exactly one cell is selected; AND-OR the selected cell's contents
  always_comb begin
    front_slot  = '0;
    front_key   = '0;
    front_match = 1'b0;
    front_used  = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (stat[i].sel) begin
        front_slot  = front_slot | cell_slot[i];
        front_key   = front_key | cell_key[i];
        front_match = front_match | stat[i].match;
        front_used  = front_used | stat[i].used;
      end
    end
  end

  assign slot_ext = {{SLOT_OUT_W{1'b0}}, front_slot};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (update) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      m_axis_tdata[0]     <= front_match;
      m_axis_tdata[3:1]   <= slot_ext[SLOT_OUT_W-1:0];
      m_axis_tdata[4]     <= front_used && !front_match;
      m_axis_tdata[36:5]  <= (front_used && !front_match) ? front_key : '0;
      m_axis_tdata[39:37] <= '0;
    end
  end

endmodule

/* hdl/lsd_cell.sv */
// One recency position of the directory: slot id, key and used flag.
module lsd_cell #(
  parameter int SLOT_W     = 3,
  parameter int RESET_SLOT = 0,
  parameter bit IS_LAST    = 1'b0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                update,
  input  logic                force_load,
  input  lsd_pkg::key_t       lookup_key,
  input  logic [SLOT_W-1:0]   prev_slot,
  input  lsd_pkg::key_t       prev_key,
  input  logic                prev_used,
  input  logic                taken_in,
  output logic                taken_out,
  output logic [SLOT_W-1:0]   slot,
  output lsd_pkg::key_t       key,
  output logic                used,
  output lsd_pkg::cell_stat_t stat
);
  import lsd_pkg::*;

  logic match;
  logic sel;

  // unused cells never match; force load skips the search
  assign match = used && (force_load == OP_LOOKUP) && (key == lookup_key);
  // first match or first unused cell wins, last cell is the fallback
  assign sel   = !taken_in && (match || !used || IS_LAST);
  assign taken_out = taken_in || sel;

  assign stat = '{sel: sel, match: match, used: used};

  // every cell from the front up to the target position moves back one place
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= SLOT_W'(RESET_SLOT);
      key  <= '0;
      used <= 1'b0;
    end else if (update && !taken_in) begin
      slot <= prev_slot;
      key  <= prev_key;
      used <= prev_used;
    end
  end

endmodule
